@@ design/lsrc_pkg.sv @@
// Shared constants and types for the line segment rectangle clipper.
`timescale 1ns / 1ps
package lsrc_pkg;

    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int NUM_SIDES = 4;

    // Window register indexes
    typedef enum logic [1:0] {
        REG_WIN_LEFT   = 2'd0,
        REG_WIN_BOTTOM = 2'd1,
        REG_WIN_RIGHT  = 2'd2,
        REG_WIN_TOP    = 2'd3
    } lsrc_reg_t;

    localparam int RST_WIN_LEFT   = 0;
    localparam int RST_WIN_BOTTOM = 0;
    localparam int RST_WIN_RIGHT  = 639;
    localparam int RST_WIN_TOP    = 479;

    // Per-side flags, order left, right, bottom, top
    typedef struct packed {
        logic [NUM_SIDES-1:0] p_zero;
        logic [NUM_SIDES-1:0] p_neg;
        logic [NUM_SIDES-1:0] q_neg;
        logic [NUM_SIDES-1:0] sat;
    } lsrc_flags_t;

endpackage

@@ design/lsrc_front.sv @@
// Front stage: direction vector, per-side p/q terms, magnitudes and flags.
`timescale 1ns / 1ps
module lsrc_front #(
    parameter int COORD_BITS = lsrc_pkg::DEF_COORD_BITS
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    input  logic signed [COORD_BITS-1:0]                 x0,
    input  logic signed [COORD_BITS-1:0]                 y0,
    input  logic signed [COORD_BITS-1:0]                 x1,
    input  logic signed [COORD_BITS-1:0]                 y1,
    input  logic signed [COORD_BITS-1:0]                 win_left,
    input  logic signed [COORD_BITS-1:0]                 win_bottom,
    input  logic signed [COORD_BITS-1:0]                 win_right,
    input  logic signed [COORD_BITS-1:0]                 win_top,
    output logic                                         out_valid,
    output logic [lsrc_pkg::NUM_SIDES-1:0][COORD_BITS:0]   rem,
    output logic [lsrc_pkg::NUM_SIDES-1:0][COORD_BITS-1:0] dvs,
    output lsrc_pkg::lsrc_flags_t                        flags,
    output logic signed [COORD_BITS-1:0]                 x0_out,
    output logic signed [COORD_BITS-1:0]                 y0_out,
    output logic signed [COORD_BITS:0]                   vx_out,
    output logic signed [COORD_BITS:0]                   vy_out
);
    import lsrc_pkg::*;

    localparam int CW = COORD_BITS;

    logic signed [CW:0] vx, vy;
    logic signed [CW:0] p_side [NUM_SIDES];
    logic signed [CW:0] q_side [NUM_SIDES];
    logic [CW:0]        p_abs  [NUM_SIDES];
    logic [CW:0]        q_abs  [NUM_SIDES];

    logic                               valid_reg;
    logic [NUM_SIDES-1:0][CW:0]         rem_reg, rem_next;
    logic [NUM_SIDES-1:0][CW-1:0]       dvs_reg, dvs_next;
    lsrc_flags_t                        flags_reg, flags_next;
    logic signed [CW-1:0]               x0_reg, y0_reg;
    logic signed [CW:0]                 vx_reg, vy_reg;

    always_comb
    begin
        vx = (CW+1)'(x1) - (CW+1)'(x0);
        vy = (CW+1)'(y1) - (CW+1)'(y0);
        p_side[0] = -vx;
        q_side[0] = (CW+1)'(x0) - (CW+1)'(win_left);
        p_side[1] = vx;
        q_side[1] = (CW+1)'(win_right) - (CW+1)'(x0);
        p_side[2] = -vy;
        q_side[2] = (CW+1)'(y0) - (CW+1)'(win_bottom);
        p_side[3] = vy;
        q_side[3] = (CW+1)'(win_top) - (CW+1)'(y0);
        for (int s = 0; s < NUM_SIDES; s++)
        begin
            p_abs[s] = p_side[s][CW] ? (CW+1)'(-p_side[s]) : (CW+1)'(p_side[s]);
            q_abs[s] = q_side[s][CW] ? (CW+1)'(-q_side[s]) : (CW+1)'(q_side[s]);
            rem_next[s]          = {1'b0, q_abs[s][CW-1:0]};
            dvs_next[s]          = p_abs[s][CW-1:0];
            flags_next.p_zero[s] = (p_side[s] == '0);
            flags_next.p_neg[s]  = p_side[s][CW];
            flags_next.q_neg[s]  = q_side[s][CW];
            // |q| >= 2|p| means the ratio clamps at two
            flags_next.sat[s]    = ({1'b0, q_abs[s][CW-1:0]} >= {p_abs[s][CW-1:0], 1'b0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        flags_reg <= flags_next;
        x0_reg    <= x0;
        y0_reg    <= y0;
        vx_reg    <= vx;
        vy_reg    <= vy;
    end

    assign out_valid = valid_reg;
    assign rem       = rem_reg;
    assign dvs       = dvs_reg;
    assign flags     = flags_reg;
    assign x0_out    = x0_reg;
    assign y0_out    = y0_reg;
    assign vx_out    = vx_reg;
    assign vy_out    = vy_reg;

endmodule

@@ design/lsrc_div_step.sv @@
// One restoring-division step: one quotient bit for one side, registered.
`timescale 1ns / 1ps
module lsrc_div_step #(
    parameter int COORD_BITS = lsrc_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = lsrc_pkg::DEF_FRAC_BITS
) (
    input  logic                  clk,
    input  logic [COORD_BITS:0]   rem_in,
    input  logic [COORD_BITS-1:0] dvs_in,
    input  logic [FRAC_BITS:0]    quo_in,
    output logic [COORD_BITS:0]   rem_out,
    output logic [COORD_BITS-1:0] dvs_out,
    output logic [FRAC_BITS:0]    quo_out
);
    import lsrc_pkg::*;

    localparam int CW = COORD_BITS;

    logic            bit_q;
    logic [CW:0]     diff;
    logic [CW:0]     rem_reg, rem_next;
    logic [CW-1:0]   dvs_reg;
    logic [FRAC_BITS:0] quo_reg, quo_next;

    always_comb
    begin
        bit_q    = (rem_in >= {1'b0, dvs_in});
        diff     = bit_q ? (rem_in - {1'b0, dvs_in}) : rem_in;
        rem_next = {diff[CW-1:0], 1'b0};
        quo_next = {quo_in[FRAC_BITS-1:0], bit_q};
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_in;
        quo_reg <= quo_next;
    end

    assign rem_out = rem_reg;
    assign dvs_out = dvs_reg;
    assign quo_out = quo_reg;

endmodule

@@ design/lsrc_select.sv @@
// Signed ratios, entry/exit parameters and the accept decision.
`timescale 1ns / 1ps
module lsrc_select #(
    parameter int FRAC_BITS = lsrc_pkg::DEF_FRAC_BITS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    input  logic [lsrc_pkg::NUM_SIDES-1:0][FRAC_BITS:0] quo,
    input  lsrc_pkg::lsrc_flags_t                      flags,
    output logic                                       out_valid,
    output logic                                       keep,
    output logic signed [FRAC_BITS+2:0]                t_in,
    output logic signed [FRAC_BITS+2:0]                t_out
);
    import lsrc_pkg::*;

    localparam int TW = FRAC_BITS + 3;

    logic [TW-1:0]        t_mag [NUM_SIDES];
    logic signed [TW-1:0] t_side [NUM_SIDES];
    logic signed [TW-1:0] t_in_next, t_out_next;
    logic                 keep_next;

    logic                 valid_reg, keep_reg;
    logic signed [TW-1:0] t_in_reg, t_out_reg;

    always_comb
    begin
        t_in_next  = '0;
        t_out_next = TW'(1) <<< FRAC_BITS;
        keep_next  = 1'b1;
        for (int s = 0; s < NUM_SIDES; s++)
        begin
            t_mag[s]  = flags.sat[s] ? (TW'(1) << (FRAC_BITS + 1)) : TW'(quo[s]);
            t_side[s] = (flags.p_neg[s] ^ flags.q_neg[s]) ? -$signed(t_mag[s])
                                                          : $signed(t_mag[s]);
            if (flags.p_zero[s])
            begin
                if (flags.q_neg[s])
                begin
                    keep_next = 1'b0;
                end
            end
            else if (flags.p_neg[s])
            begin
                if (t_side[s] > t_in_next)
                begin
                    t_in_next = t_side[s];
                end
            end
            else if (t_side[s] < t_out_next)
            begin
                t_out_next = t_side[s];
            end
        end
        // entry only grows and exit only shrinks, so one final check suffices
        if (t_in_next > t_out_next)
        begin
            keep_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        keep_reg  <= keep_next;
        t_in_reg  <= t_in_next;
        t_out_reg <= t_out_next;
    end

    assign out_valid = valid_reg;
    assign keep      = keep_reg;
    assign t_in      = t_in_reg;
    assign t_out     = t_out_reg;

endmodule

@@ design/lsrc_cut.sv @@
// Endpoint interpolation: multiply stage, then add, truncate and output register.
`timescale 1ns / 1ps
module lsrc_cut #(
    parameter int COORD_BITS = lsrc_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = lsrc_pkg::DEF_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         keep,
    input  logic signed [FRAC_BITS+2:0]  t_in,
    input  logic signed [FRAC_BITS+2:0]  t_out,
    input  logic signed [COORD_BITS-1:0] x0,
    input  logic signed [COORD_BITS-1:0] y0,
    input  logic signed [COORD_BITS:0]   vx,
    input  logic signed [COORD_BITS:0]   vy,
    output logic                         out_valid,
    output logic                         visible,
    output logic signed [COORD_BITS-1:0] sx,
    output logic signed [COORD_BITS-1:0] sy,
    output logic signed [COORD_BITS-1:0] ex,
    output logic signed [COORD_BITS-1:0] ey
);
    import lsrc_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int TW = FRAC_BITS + 3;
    localparam int PW = TW + CW + 1;
    localparam int SW = PW + 1;

    function automatic logic signed [CW-1:0] finish(input logic signed [CW-1:0] c0,
                                                   input logic signed [PW-1:0] prod);
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] adj;
        sum = ($signed(SW'(c0)) <<< FRAC_BITS) + $signed(SW'(prod));
        // bias negatives so the arithmetic shift truncates toward zero
        adj = sum[SW-1] ? sum + ((SW'(1) <<< FRAC_BITS) - SW'(1)) : sum;
        adj = adj >>> FRAC_BITS;
        return adj[CW-1:0];
    endfunction

    logic                 m_valid_reg, m_keep_reg;
    logic signed [PW-1:0] m_sx_reg, m_sy_reg, m_ex_reg, m_ey_reg;
    logic signed [CW-1:0] m_x0_reg, m_y0_reg;

    logic                 o_valid_reg, o_vis_reg;
    logic signed [CW-1:0] o_sx_reg, o_sy_reg, o_ex_reg, o_ey_reg;
    logic signed [CW-1:0] o_sx_next, o_sy_next, o_ex_next, o_ey_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= in_valid;
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_keep_reg <= keep;
        m_sx_reg   <= PW'(t_in * vx);
        m_sy_reg   <= PW'(t_in * vy);
        m_ex_reg   <= PW'(t_out * vx);
        m_ey_reg   <= PW'(t_out * vy);
        m_x0_reg   <= x0;
        m_y0_reg   <= y0;
    end

    always_comb
    begin
        o_sx_next = '0;
        o_sy_next = '0;
        o_ex_next = '0;
        o_ey_next = '0;
        if (m_keep_reg)
        begin
            o_sx_next = finish(m_x0_reg, m_sx_reg);
            o_sy_next = finish(m_y0_reg, m_sy_reg);
            o_ex_next = finish(m_x0_reg, m_ex_reg);
            o_ey_next = finish(m_y0_reg, m_ey_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        o_vis_reg <= m_keep_reg;
        o_sx_reg  <= o_sx_next;
        o_sy_reg  <= o_sy_next;
        o_ex_reg  <= o_ex_next;
        o_ey_reg  <= o_ey_next;
    end

    assign out_valid = o_valid_reg;
    assign visible   = o_vis_reg;
    assign sx        = o_sx_reg;
    assign sy        = o_sy_reg;
    assign ex        = o_ex_reg;
    assign ey        = o_ey_reg;

endmodule

@@ design/line_segment_rect_clipper_core.sv @@
// Top level of the Liang-Barsky segment clipper pipeline.
`timescale 1ns / 1ps
// Usage:
//   Segment channel: drive start_x/start_y/end_x/end_y and raise start; the
//   item is taken on any rising edge where start is high and busy is low.
//   busy is always low, so one segment can be issued every clock.
//   Result channel: done pulses for one cycle with visible and the clipped
//   endpoints. Rejected segments report visible = 0 and zero coordinates.
//   Results come out in issue order and cannot be held off by the receiver.
//   Throughput: one item per clock. The restoring divider produces one quotient
//   bit per stage, FRAC_BITS + 1 stages, four sides in parallel lanes.
//   Window port: cfg_valid/cfg_ready with cfg_index (0 left, 1 bottom,
//   2 right, 3 top) and cfg_data; cfg_ready is always high. Write the window
//   only while no item is in flight.
//   Reset (rst_n low, async): pipeline valid bits clear, window returns to
//   left 0, bottom 0, right 639, top 479. No items are lost across stages:
//   the pipeline advances every cycle.
module line_segment_rect_clipper_core #(
    parameter int COORD_BITS = lsrc_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = lsrc_pkg::DEF_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  lsrc_pkg::lsrc_reg_t          cfg_index,
    input  logic signed [COORD_BITS-1:0] cfg_data,
    output logic                         done,
    output logic                         visible,
    output logic signed [COORD_BITS-1:0] clip_start_x,
    output logic signed [COORD_BITS-1:0] clip_start_y,
    output logic signed [COORD_BITS-1:0] clip_end_x,
    output logic signed [COORD_BITS-1:0] clip_end_y
);
    import lsrc_pkg::*;

    localparam int CW      = COORD_BITS;
    localparam int DSTAGES = FRAC_BITS + 1;
    localparam int LATENCY = FRAC_BITS + 5;

    // Window registers
    logic signed [CW-1:0] win_left_reg, win_bottom_reg, win_right_reg, win_top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= CW'(RST_WIN_LEFT);
            win_bottom_reg <= CW'(RST_WIN_BOTTOM);
            win_right_reg  <= CW'(RST_WIN_RIGHT);
            win_top_reg    <= CW'(RST_WIN_TOP);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WIN_LEFT:   win_left_reg   <= cfg_data;
                REG_WIN_BOTTOM: win_bottom_reg <= cfg_data;
                REG_WIN_RIGHT:  win_right_reg  <= cfg_data;
                REG_WIN_TOP:    win_top_reg    <= cfg_data;
                default:        win_left_reg   <= win_left_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Front stage
    logic                         f_valid;
    logic [NUM_SIDES-1:0][CW:0]   f_rem;
    logic [NUM_SIDES-1:0][CW-1:0] f_dvs;
    lsrc_flags_t                  f_flags;
    logic signed [CW-1:0]         f_x0, f_y0;
    logic signed [CW:0]           f_vx, f_vy;

    lsrc_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .x0         (start_x),
        .y0         (start_y),
        .x1         (end_x),
        .y1         (end_y),
        .win_left   (win_left_reg),
        .win_bottom (win_bottom_reg),
        .win_right  (win_right_reg),
        .win_top    (win_top_reg),
        .out_valid  (f_valid),
        .rem        (f_rem),
        .dvs        (f_dvs),
        .flags      (f_flags),
        .x0_out     (f_x0),
        .y0_out     (f_y0),
        .vx_out     (f_vx),
        .vy_out     (f_vy)
    );

    // Divider lanes: stage 0 is fed from the front stage
    logic [NUM_SIDES-1:0][CW:0]        d_rem [DSTAGES+1];
    logic [NUM_SIDES-1:0][CW-1:0]      d_dvs [DSTAGES+1];
    logic [NUM_SIDES-1:0][FRAC_BITS:0] d_quo [DSTAGES+1];

    assign d_rem[0] = f_rem;
    assign d_dvs[0] = f_dvs;
    assign d_quo[0] = '0;

    for (genvar k = 0; k < DSTAGES; k++)
    begin : g_stage
        for (genvar s = 0; s < NUM_SIDES; s++)
        begin : g_lane
            lsrc_div_step #(
                .COORD_BITS (COORD_BITS),
                .FRAC_BITS  (FRAC_BITS)
            ) u_step (
                .clk     (clk),
                .rem_in  (d_rem[k][s]),
                .dvs_in  (d_dvs[k][s]),
                .quo_in  (d_quo[k][s]),
                .rem_out (d_rem[k+1][s]),
                .dvs_out (d_dvs[k+1][s]),
                .quo_out (d_quo[k+1][s])
            );
        end
    end

    // Side data travels alongside the divider lanes
    logic [DSTAGES-1:0]   sd_valid_reg;
    lsrc_flags_t          sd_flags_reg [DSTAGES];
    logic signed [CW-1:0] sd_x0_reg [DSTAGES];
    logic signed [CW-1:0] sd_y0_reg [DSTAGES];
    logic signed [CW:0]   sd_vx_reg [DSTAGES];
    logic signed [CW:0]   sd_vy_reg [DSTAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sd_valid_reg <= '0;
        end
        else
        begin
            sd_valid_reg <= {sd_valid_reg[DSTAGES-2:0], f_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        sd_flags_reg[0] <= f_flags;
        sd_x0_reg[0]    <= f_x0;
        sd_y0_reg[0]    <= f_y0;
        sd_vx_reg[0]    <= f_vx;
        sd_vy_reg[0]    <= f_vy;
        for (int k = 1; k < DSTAGES; k++)
        begin
            sd_flags_reg[k] <= sd_flags_reg[k-1];
            sd_x0_reg[k]    <= sd_x0_reg[k-1];
            sd_y0_reg[k]    <= sd_y0_reg[k-1];
            sd_vx_reg[k]    <= sd_vx_reg[k-1];
            sd_vy_reg[k]    <= sd_vy_reg[k-1];
        end
    end

    // Entry/exit selection
    logic                        s_valid, s_keep;
    logic signed [FRAC_BITS+2:0] s_t_in, s_t_out;
    logic signed [CW-1:0]        s_x0_reg, s_y0_reg;
    logic signed [CW:0]          s_vx_reg, s_vy_reg;

    lsrc_select #(.FRAC_BITS(FRAC_BITS)) u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sd_valid_reg[DSTAGES-1]),
        .quo       (d_quo[DSTAGES]),
        .flags     (sd_flags_reg[DSTAGES-1]),
        .out_valid (s_valid),
        .keep      (s_keep),
        .t_in      (s_t_in),
        .t_out     (s_t_out)
    );

    always_ff @(posedge clk)
    begin
        s_x0_reg <= sd_x0_reg[DSTAGES-1];
        s_y0_reg <= sd_y0_reg[DSTAGES-1];
        s_vx_reg <= sd_vx_reg[DSTAGES-1];
        s_vy_reg <= sd_vy_reg[DSTAGES-1];
    end

    // Interpolation and output register
    lsrc_cut #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_cut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .keep      (s_keep),
        .t_in      (s_t_in),
        .t_out     (s_t_out),
        .x0        (s_x0_reg),
        .y0        (s_y0_reg),
        .vx        (s_vx_reg),
        .vy        (s_vy_reg),
        .out_valid (done),
        .visible   (visible),
        .sx        (clip_start_x),
        .sy        (clip_start_y),
        .ex        (clip_end_x),
        .ey        (clip_end_y)
    );

    // Every result traces back to an accepted item at the pipeline input
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching item");

    // Rejected items report zero coordinates
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !visible) |-> (clip_start_x == '0 && clip_start_y == '0 &&
                                clip_end_x == '0 && clip_end_y == '0))
        else $error("rejected item with nonzero coordinates");

    // Selected entry never exceeds exit on a kept item
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid && s_keep) |-> (s_t_in <= s_t_out))
        else $error("kept item with entry past exit");

endmodule

@@ bench/tb_line_segment_rect_clipper_core.sv @@
// Testbench for the Liang-Barsky segment clipper core.
`timescale 1ns / 1ps
// Segments go in on the start/busy command channel and are predicted with a
// 64-bit fixed-point model of the clip. Each done pulse is checked, field by
// field, against the oldest pending prediction. The window registers are
// rewritten between phases, only once the pipeline has drained.
module tb_line_segment_rect_clipper_core;
    import lsrc_pkg::*;

    localparam int CB      = 16;
    localparam int FB      = 16;
    localparam int LATENCY = FB + 5;
    localparam int WD_MAX  = 2000;
    localparam longint T_ONE = 64'sd1 << FB;
    localparam longint T_SAT = 2 * T_ONE;

    typedef struct {
        logic          vis;
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
    } clip_res_t;

    logic clk, rst_n;
    logic start, busy;
    logic signed [CB-1:0] start_x, start_y, end_x, end_y;
    logic cfg_valid, cfg_ready;
    lsrc_reg_t cfg_index;
    logic signed [CB-1:0] cfg_data;
    logic done, visible;
    logic signed [CB-1:0] clip_start_x, clip_start_y, clip_end_x, clip_end_y;

    // window copy used for prediction
    longint w_left, w_bottom, w_right, w_top;

    clip_res_t pending_clips[$];
    int err_count;
    int seg_count;
    int vis_count;
    int idle_cycles;
    bit gaps_on;

    line_segment_rect_clipper_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ratio q/p in fixed point, truncated toward zero, then saturated
    function automatic longint clip_ratio(longint q, longint p);
        longint t;
        t = (q * T_ONE) / p;
        if (t > T_SAT) t = T_SAT;
        if (t < -T_SAT) t = -T_SAT;
        return t;
    endfunction

    function automatic logic [CB-1:0] cut_at(longint c0, longint v, longint t);
        longint r;
        r = (c0 * T_ONE + t * v) / T_ONE;
        return r[CB-1:0];
    endfunction

    function automatic clip_res_t clip_segment(longint x0, longint y0,
                                               longint x1, longint y1);
        clip_res_t r;
        longint vx, vy, p, q, t, t_in, t_out;
        longint pv[4];
        longint qv[4];
        bit keep;
        vx = x1 - x0;
        vy = y1 - y0;
        t_in = 0;
        t_out = T_ONE;
        keep = 1'b1;
        pv[0] = -vx; qv[0] = x0 - w_left;
        pv[1] = vx;  qv[1] = w_right - x0;
        pv[2] = -vy; qv[2] = y0 - w_bottom;
        pv[3] = vy;  qv[3] = w_top - y0;
        for (int s = 0; s < 4; s++)
        begin
            if (keep)
            begin
                p = pv[s];
                q = qv[s];
                if (p < 0)
                begin
                    t = clip_ratio(q, p);
                    if (t > t_in) t_in = t;
                end
                else if (p > 0)
                begin
                    t = clip_ratio(q, p);
                    if (t < t_out) t_out = t;
                end
                else if (q < 0)
                    keep = 1'b0;
                if (t_in > t_out) keep = 1'b0;
            end
        end
        r = '{1'b0, '0, '0, '0, '0};
        if (keep)
        begin
            r.vis = 1'b1;
            r.sx = cut_at(x0, vx, t_in);
            r.sy = cut_at(y0, vy, t_in);
            r.ex = cut_at(x0, vx, t_out);
            r.ey = cut_at(y0, vy, t_out);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        err_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // result checker: done is a one-cycle strobe, sampled at the rising edge
    always @(posedge clk)
    begin
        clip_res_t w;
        if (rst_n && done)
        begin
            if (pending_clips.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                w = pending_clips.pop_front();
                if (visible !== w.vis) report_mismatch("visible", visible, w.vis);
                if (clip_start_x !== w.sx)
                    report_mismatch("clip_start_x", clip_start_x, $signed(w.sx));
                if (clip_start_y !== w.sy)
                    report_mismatch("clip_start_y", clip_start_y, $signed(w.sy));
                if (clip_end_x !== w.ex)
                    report_mismatch("clip_end_x", clip_end_x, $signed(w.ex));
                if (clip_end_y !== w.ey)
                    report_mismatch("clip_end_y", clip_end_y, $signed(w.ey));
                if (w.vis) vis_count++;
            end
        end
    end

    // watchdog: cycles with nothing accepted on any channel
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_MAX)
        begin
            $display("watchdog expired, %0d results pending", pending_clips.size());
            $display("tb_line_segment_rect_clipper_core: errors");
            $finish;
        end
    end

    // one register write; valid stays high for the caller to drop or reuse
    task automatic write_window(lsrc_reg_t idx, logic signed [CB-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_WIN_LEFT:   w_left   = val;
            REG_WIN_BOTTOM: w_bottom = val;
            REG_WIN_RIGHT:  w_right  = val;
            REG_WIN_TOP:    w_top    = val;
        endcase
        @(negedge clk);
    endtask

    task automatic set_window(int l, int b, int r, int t);
        write_window(REG_WIN_LEFT, l[CB-1:0]);
        write_window(REG_WIN_BOTTOM, b[CB-1:0]);
        write_window(REG_WIN_RIGHT, r[CB-1:0]);
        write_window(REG_WIN_TOP, t[CB-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // send one segment; start stays high into the next item when no gap follows
    task automatic send_segment(logic signed [CB-1:0] x0, logic signed [CB-1:0] y0,
                                logic signed [CB-1:0] x1, logic signed [CB-1:0] y1);
        int gap;
        start   <= 1'b1;
        start_x <= x0;
        start_y <= y0;
        end_x   <= x1;
        end_y   <= y1;
        do @(posedge clk); while (busy);
        pending_clips.push_back(clip_segment(x0, y0, x1, y1));
        seg_count++;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            start <= 1'b0;
            start_x <= CB'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    // let everything in flight arrive, then the pipeline empties
    task automatic drain;
        start <= 1'b0;
        while (pending_clips.size() != 0) @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    function automatic logic signed [CB-1:0] rnd_coord(int lo, int hi);
        case ($urandom_range(0, 7))
            0: return CB'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return CB'(lo + $signed($urandom_range(0, hi - lo)));
        endcase
    endfunction

    task automatic test_directed_default_window;
        gaps_on = 1'b0;
        send_segment(10, 10, 100, 200);            // fully inside
        send_segment(-100, 240, 800, 240);         // crosses left and right
        send_segment(320, -50, 320, 600);          // crosses bottom and top
        send_segment(-10, -10, -100, -100);        // fully outside
        send_segment(50, 50, 50, 50);              // degenerate, inside
        send_segment(0, 0, 0, 0);                  // degenerate, on corner
        send_segment(700, 50, 700, 50);            // degenerate, outside
        send_segment(-5, 100, -5, 300);            // parallel to left, outside
        send_segment(0, 100, 0, 300);              // parallel on left edge
        send_segment(100, 500, 300, 500);          // parallel above top
        send_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_segment(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_segment(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_segment(-1, -1, 1, 1);                // short, clip at start
        send_segment(-700, 240, 1300, 240);        // crosses left and right
        send_segment(639, 479, 700, 600);
        drain();
    endtask

    task automatic test_inverted_window;
        set_window(100, 100, 50, 50);
        send_segment(60, 60, 90, 90);
        send_segment(75, 75, 75, 75);
        send_segment(-1000, -1000, 1000, 1000);
        drain();
    endtask

    task automatic test_extreme_windows;
        set_window(-32768, -32768, 32767, 32767);
        send_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_segment(16'sh7fff, 0, 16'sh8000, 0);
        send_segment(-12345, 999, 23456, -30000);
        drain();
        set_window(5, 5, 5, 5);
        send_segment(0, 0, 10, 10);
        send_segment(5, 5, 5, 5);
        send_segment(0, 5, 10, 5);
        drain();
    endtask

    // random segments over a few windows; most cross the window edges
    task automatic test_random_windows(int n, bit with_gaps);
        int l, b, r, t, span;
        gaps_on = with_gaps;
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 5 && $urandom_range(0, 1))
                set_window(-32768, -32768, 32767, 32767);
            else
            begin
                l = $signed($urandom_range(0, 4000)) - 2000;
                b = $signed($urandom_range(0, 4000)) - 2000;
                r = l + $urandom_range(0, 3000);
                t = b + $urandom_range(0, 3000);
                if ($urandom_range(0, 9) == 0) r = l - $urandom_range(1, 50);
                set_window(l, b, r, t);
            end
            span = 2000;
            for (int i = 0; i < n / 6; i++)
                send_segment(rnd_coord(int'(w_left - span), int'(w_right + span)),
                             rnd_coord(int'(w_bottom - span), int'(w_top + span)),
                             rnd_coord(int'(w_left - span), int'(w_right + span)),
                             rnd_coord(int'(w_bottom - span), int'(w_top + span)));
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        start_x = '0; start_y = '0; end_x = '0; end_y = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_WIN_LEFT;
        cfg_data = '0;
        err_count = 0; seg_count = 0; vis_count = 0; idle_cycles = 0;
        gaps_on = 1'b0;
        w_left = RST_WIN_LEFT; w_bottom = RST_WIN_BOTTOM;
        w_right = RST_WIN_RIGHT; w_top = RST_WIN_TOP;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_default_window();
        test_inverted_window();
        test_extreme_windows();
        test_random_windows(1200, 1'b1);
        test_random_windows(330, 1'b0);   // back to back, no gaps

        $display("covered %0d segments, %0d visible, over default, inverted,",
                 seg_count, vis_count);
        $display("full-range, single-point and random windows");
        if (err_count == 0)
            $display("tb_line_segment_rect_clipper_core: clean");
        else
            $display("tb_line_segment_rect_clipper_core: errors");
        $finish;
    end
endmodule
